>>> hw/rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// shared widths, operation and status codes, and the result bundle of the
// keyed compacting table
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int OP_W    = 3;
    localparam int KEY_W   = 8;
    localparam int SIG_W   = 16;
    localparam int RIDX_W  = 4;
    localparam int STAT_W  = 3;
    localparam int OKEY_W  = 4;
    localparam int TOTAL_W = 5;

    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_SET        = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_END = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_KEY = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_KEY_RANGE   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY       = 3'd4;
    localparam logic [STAT_W-1:0] STAT_INDEX_RANGE = 3'd5;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OKEY_W-1:0]  out_key;
        logic [SIG_W-1:0]   out_signal;
        logic [TOTAL_W-1:0] entry_total;
    } kct_result_t;

endpackage

>>> hw/rtl/kct_ram.sv
// ----------------------------------------------------------------------------
// kct_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module kct_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// sequencer of the keyed compacting table: key search through the shared
// compare, append, overwrite, remove-last, shift-down compaction and indexed read
// ----------------------------------------------------------------------------
module kct_ctrl #(
    parameter int CAPACITY = kct_pkg::CAPACITY_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [kct_pkg::OP_W-1:0]   s_op,
    input  logic [kct_pkg::KEY_W-1:0]  s_key,
    input  logic [kct_pkg::SIG_W-1:0]  s_signal_value,
    input  logic [kct_pkg::RIDX_W-1:0] s_read_index,
    output logic                       res_valid,
    input  logic                       res_ready,
    output kct_pkg::kct_result_t       res
);

    import kct_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = IDX_W + SIG_W;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SEARCH    = 3'd1;
    localparam logic [2:0] S_SHIFT_RD  = 3'd2;
    localparam logic [2:0] S_SHIFT_WR  = 3'd3;
    localparam logic [2:0] S_READ_WAIT = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SIG_W-1:0]  sig_reg, sig_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [OKEY_W-1:0] rkey_reg, rkey_next;
    logic [SIG_W-1:0]  rsig_reg, rsig_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    logic key_hit;
    logic in_key_range;
    logic in_idx_range;

    kct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign key_hit      = pend_reg && (rd_data[ENT_W-1:SIG_W] == key_reg[IDX_W-1:0]);
    assign in_key_range = 32'(s_key) < 32'(CAPACITY);
    assign in_idx_range = 32'(s_read_index) < 32'(count_reg);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        sig_next     = sig_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        cmp_idx_next = cmp_idx_reg;
        status_next  = status_reg;
        rkey_next    = rkey_reg;
        rsig_next    = rsig_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];
        wr_data      = {key_reg[IDX_W-1:0], sig_reg};
        rd_en        = 1'b0;
        rd_addr      = scan_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_op;
                    key_next    = s_key;
                    sig_next    = s_signal_value;
                    scan_next   = '0;
                    pend_next   = 1'b0;
                    status_next = STAT_OK;
                    rkey_next   = '0;
                    rsig_next   = '0;
                    state_next  = S_DONE;
                    case (s_op)
                        OP_ADD, OP_SET: begin
                            if (in_key_range) begin
                                state_next = S_SEARCH;
                            end else begin
                                status_next = STAT_KEY_RANGE;
                            end
                        end
                        OP_REMOVE_KEY: begin
                            if (in_key_range) begin
                                state_next = S_SEARCH;
                            end else begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        OP_REMOVE_END: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                count_next = CNT_W'(count_reg - 1'b1);
                            end
                        end
                        OP_READ: begin
                            if (in_idx_range) begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(s_read_index);
                                state_next = S_READ_WAIT;
                            end else begin
                                status_next = STAT_INDEX_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                if (key_hit) begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    case (op_reg)
                        OP_SET: begin
                            wr_en   = 1'b1;
                            wr_addr = cmp_idx_reg;
                        end
                        OP_REMOVE_KEY: begin
                            scan_next  = CNT_W'(cmp_idx_reg) + 1'b1;
                            state_next = S_SHIFT_RD;
                        end
                        default: begin
                            status_next = STAT_DUPLICATE;
                        end
                    endcase
                end else if (scan_reg < count_reg) begin
                    rd_en        = 1'b1;
                    rd_addr      = scan_reg[IDX_W-1:0];
                    pend_next    = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = CNT_W'(scan_reg + 1'b1);
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    state_next = S_DONE;
                    if (op_reg == OP_REMOVE_KEY) begin
                        status_next = STAT_NOT_FOUND;
                    end else begin
                        // absent key, append at the end
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                end
            end

            S_SHIFT_RD: begin
                if (scan_reg < count_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = scan_reg[IDX_W-1:0];
                    state_next = S_SHIFT_WR;
                end else begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    state_next = S_DONE;
                end
            end

            S_SHIFT_WR: begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(scan_reg - 1'b1);
                wr_data    = rd_data;
                scan_next  = CNT_W'(scan_reg + 1'b1);
                state_next = S_SHIFT_RD;
            end

            S_READ_WAIT: begin
                rkey_next  = OKEY_W'(rd_data[ENT_W-1:SIG_W]);
                rsig_next  = rd_data[SIG_W-1:0];
                state_next = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        op_reg      <= op_next;
        key_reg     <= key_next;
        sig_reg     <= sig_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        rkey_reg    <= rkey_next;
        rsig_reg    <= rsig_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.out_key     = rkey_reg;
    assign res.out_signal  = rsig_reg;
    assign res.entry_total = TOTAL_W'(count_reg);

endmodule

>>> hw/rtl/keyed_compacting_table.sv
// ----------------------------------------------------------------------------
// keyed_compacting_table
// ordered table of unique (key, signal) pairs with add, set, remove-last,
// remove-by-key with compaction, and indexed read
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one command beat (op, key, signal_value, read_index),
//   m_ channel returns exactly one result beat per command (status, out_key,
//   out_signal, entry_total), both valid/ready.
//   one command is in work at a time; s_ready is high only while the
//   sequencer is idle. the table sits in a ram with one write and one
//   registered read port, and a single key compare is reused per entry.
//   add / set search streams one entry per cycle; remove by key searches,
//   then shifts every later entry down by one (a read, then a write, each).
//   the result is handed from the sequencer into an output register,
//   so a new command is taken while a result still waits on m_ready.
//   a stalled receiver holds the result and blocks only the next completion.
//   reset empties the table (count to 0); table contents need no clearing.
// ----------------------------------------------------------------------------
module keyed_compacting_table #(
    parameter int CAPACITY = kct_pkg::CAPACITY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kct_pkg::OP_W-1:0]      s_op,
    input  logic [kct_pkg::KEY_W-1:0]     s_key,
    input  logic [kct_pkg::SIG_W-1:0]     s_signal_value,
    input  logic [kct_pkg::RIDX_W-1:0]    s_read_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kct_pkg::STAT_W-1:0]    m_status,
    output logic [kct_pkg::OKEY_W-1:0]    m_out_key,
    output logic [kct_pkg::SIG_W-1:0]     m_out_signal,
    output logic [kct_pkg::TOTAL_W-1:0]   m_entry_total
);

    import kct_pkg::*;

    logic        res_valid;
    logic        res_ready;
    kct_result_t res;

    logic        m_valid_reg, m_valid_next;
    kct_result_t m_res_reg, m_res_next;

    kct_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key          (s_key),
        .s_signal_value (s_signal_value),
        .s_read_index   (s_read_index),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // output register frees when empty or when its beat is taken
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_out_key     = m_res_reg.out_key;
    assign m_out_signal  = m_res_reg.out_signal;
    assign m_entry_total = m_res_reg.entry_total;

endmodule
